/* rtl/i2cb_pkg.sv */
// ----------------------------------------------------------------------------
// i2cb_pkg
// Shared types, codes and the phase level table of the I2C bit level master.
// ----------------------------------------------------------------------------
package i2cb_pkg;

   // Command codes carried in the opcode field.
   localparam logic [2:0] OP_START        = 3'd0;
   localparam logic [2:0] OP_SENSOR_START = 3'd1;
   localparam logic [2:0] OP_STOP         = 3'd2;
   localparam logic [2:0] OP_ACK          = 3'd3;
   localparam logic [2:0] OP_NACK         = 3'd4;
   localparam logic [2:0] OP_SEND         = 3'd5;
   localparam logic [2:0] OP_RECV         = 3'd6;

   // Status codes reported on the final phase.
   localparam logic [2:0] ST_READY = 3'd0;
   localparam logic [2:0] ST_BUSY  = 3'd1;
   localparam logic [2:0] ST_ERROR = 3'd2;
   localparam logic [2:0] ST_ACK   = 3'd3;
   localparam logic [2:0] ST_NACK  = 3'd4;

   // Phase timing register.
   localparam int          TICKS_W           = 16;
   localparam logic [15:0] PHASE_TICKS_RESET = 16'd200;

   // Phase index width: the longest command has 27 phases.
   localparam int PHASE_W = 5;

   // Index of the first acknowledge phase of send byte (after 8 bits of 3).
   localparam logic [4:0] SEND_ACK_PHASE = 5'd24;
   localparam logic [4:0] SEND_SCL_PHASE = 5'd25;

   // Command queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Classified command as it travels through the queue.
   typedef struct packed {
      logic [2:0]         op;
      logic [PHASE_W-1:0] last_idx;
      logic [2:0]         status;
      logic [7:0]         rx;
      logic [7:0]         tx;
   } cmd_type;

   // Line levels of one phase.
   typedef struct packed {
      logic scl;
      logic sda;
   } level_type;

   // Back part sequencer states.
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_LOAD,
      BK_EMIT,
      BK_HOLD
   } back_state_type;

   // Line levels for phase k of a command. sub is the position inside the
   // current bit of send byte, bit its data bit, held the SCL level that the
   // previous command left behind.
   function automatic level_type phase_level(input logic [2:0] op,
                                             input logic [PHASE_W-1:0] k,
                                             input logic [1:0] sub,
                                             input logic bit_val,
                                             input logic held);
      level_type lv;
      lv = '{scl: 1'b0, sda: 1'b1};
      unique case (op)
         OP_START: begin
            case (k)
               5'd0:    lv = '{scl: held, sda: 1'b1};
               5'd1:    lv = '{scl: 1'b1, sda: 1'b1};
               5'd2:    lv = '{scl: 1'b1, sda: 1'b0};
               default: lv = '{scl: 1'b0, sda: 1'b0};
            endcase
         end
         OP_SENSOR_START: begin
            case (k)
               5'd0:    lv = '{scl: 1'b0, sda: 1'b1};
               5'd1:    lv = '{scl: 1'b1, sda: 1'b1};
               5'd2:    lv = '{scl: 1'b1, sda: 1'b0};
               5'd3:    lv = '{scl: 1'b0, sda: 1'b0};
               5'd4:    lv = '{scl: 1'b1, sda: 1'b0};
               5'd5:    lv = '{scl: 1'b1, sda: 1'b1};
               default: lv = '{scl: 1'b0, sda: 1'b1};
            endcase
         end
         OP_STOP: begin
            case (k)
               5'd0:    lv = '{scl: held, sda: 1'b0};
               5'd1:    lv = '{scl: 1'b1, sda: 1'b0};
               default: lv = '{scl: 1'b1, sda: 1'b1};
            endcase
         end
         OP_ACK: begin
            case (k)
               5'd0:    lv = '{scl: held, sda: 1'b0};
               5'd1:    lv = '{scl: 1'b1, sda: 1'b0};
               5'd2:    lv = '{scl: 1'b0, sda: 1'b0};
               default: lv = '{scl: 1'b0, sda: 1'b1};
            endcase
         end
         OP_NACK: begin
            case (k)
               5'd0:    lv = '{scl: held, sda: 1'b1};
               5'd1:    lv = '{scl: 1'b1, sda: 1'b1};
               default: lv = '{scl: 1'b0, sda: 1'b1};
            endcase
         end
         OP_SEND: begin
            // Data bits are low-high-low clock pulses, then the ACK slot.
            if (k < SEND_ACK_PHASE) begin
               lv = '{scl: (sub == 2'd1), sda: bit_val};
            end else begin
               lv = '{scl: (k == SEND_SCL_PHASE), sda: 1'b1};
            end
         end
         OP_RECV: begin
            // Released data line, clock high on every odd phase.
            lv = '{scl: k[0], sda: 1'b1};
         end
         default: lv = '{scl: 1'b0, sda: 1'b1};
      endcase
      return lv;
   endfunction

endpackage

/* rtl/i2cb_if.sv */
// ----------------------------------------------------------------------------
// I2C bit level master channels
// Valid/ready channels for commands, phase words and the timing register.
// ----------------------------------------------------------------------------

// Command channel: one word per bus command.
interface i2cb_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [7:0] tx_byte;
   logic [8:0] sda_samples;

   modport source (output valid, output opcode, output tx_byte, output sda_samples,
                   input ready);
   modport sink   (input valid, input opcode, input tx_byte, input sda_samples,
                   output ready);
endinterface

// Phase channel: one word per bus phase.
interface i2cb_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic [2:0] status;
   logic [7:0] rx_byte;
   logic       last;

   modport source (output valid, output scl_out, output sda_out, output status,
                   output rx_byte, output last, input ready);
   modport sink   (input valid, input scl_out, input sda_out, input status,
                   input rx_byte, input last, output ready);
endinterface

// Register write channel: the phase length in clock cycles.
interface i2cb_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/i2cb_front.sv */
// ----------------------------------------------------------------------------
// i2cb_front
// Accepts command words and classifies them into queue entries.
// ----------------------------------------------------------------------------
module i2cb_front import i2cb_pkg::*; (
   i2cb_req_if.sink  req_ch,
   output logic      push_valid,
   input  logic      push_ready,
   output cmd_type   push_data
);

   logic       busy;
   logic [7:0] rx_rev;

   // The bus is busy when the first sample of a start finds SDA low.
   assign busy = ~req_ch.sda_samples[0];

   // Sample i becomes bit 7-i of the received byte.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         rx_rev[7-i] = req_ch.sda_samples[i];
      end
   end

   // Phase count, status and received byte of each command.
   always_comb begin
      push_data.op       = req_ch.opcode;
      push_data.tx       = req_ch.tx_byte;
      push_data.status   = ST_READY;
      push_data.rx       = 8'd0;
      push_data.last_idx = 5'd0;
      push_valid         = req_ch.valid;
      unique case (req_ch.opcode)
         OP_START: begin
            push_data.last_idx = busy ? 5'd1 : 5'd3;
            push_data.status   = busy ? ST_BUSY :
                                 (req_ch.sda_samples[1] ? ST_ERROR : ST_READY);
         end
         OP_SENSOR_START: begin
            push_data.last_idx = busy ? 5'd1 : 5'd6;
            push_data.status   = busy ? ST_BUSY : ST_READY;
         end
         OP_STOP: push_data.last_idx = 5'd2;
         OP_ACK:  push_data.last_idx = 5'd3;
         OP_NACK: push_data.last_idx = 5'd2;
         OP_SEND: begin
            push_data.last_idx = 5'd26;
            push_data.status   = req_ch.sda_samples[0] ? ST_NACK : ST_ACK;
         end
         OP_RECV: begin
            push_data.last_idx = 5'd16;
            push_data.rx       = rx_rev;
         end
         // An unused code produces no phases and is dropped here.
         default: push_valid = 1'b0;
      endcase
   end

   assign req_ch.ready = push_ready;

endmodule

/* rtl/i2cb_cmd_queue.sv */
// ----------------------------------------------------------------------------
// i2cb_cmd_queue
// Two-entry register queue between the front and back parts.
// ----------------------------------------------------------------------------
module i2cb_cmd_queue import i2cb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   // Handshakes on both sides.
   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/i2cb_back.sv */
// ----------------------------------------------------------------------------
// i2cb_back
// Phase sequencer: builds each phase word and holds it for the phase length.
// ----------------------------------------------------------------------------
module i2cb_back import i2cb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [TICKS_W-1:0] phase_ticks,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  cmd_type            pop_data,
   i2cb_rsp_if.source         rsp_ch
);

   back_state_type     state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [PHASE_W-1:0] k_ff, k_in;
   logic [1:0]         sub_ff, sub_in;
   logic [7:0]         tx_ff, tx_in;
   logic               scl_level_ff, scl_level_in;
   logic [TICKS_W-1:0] cnt_ff, cnt_in;
   logic               scl_ff, scl_in;
   logic               sda_ff, sda_in;
   logic [2:0]         status_ff, status_in;
   logic [7:0]         rx_ff, rx_in;
   logic               last_ff, last_in;
   level_type          lv;
   logic               is_last;
   logic               hold_done;

   assign lv        = phase_level(cmd_ff.op, k_ff, sub_ff, tx_ff[7], scl_level_ff);
   assign is_last   = (k_ff == cmd_ff.last_idx);
   assign hold_done = (cnt_ff >= phase_ticks);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (pop_valid) state_in = BK_LOAD;
         BK_LOAD: state_in = BK_EMIT;
         BK_EMIT: if (rsp_ch.ready) state_in = BK_HOLD;
         BK_HOLD: if (hold_done) state_in = last_ff ? BK_IDLE : BK_LOAD;
         default: state_in = BK_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      pop_ready    = (state_ff == BK_IDLE);
      rsp_ch.valid = (state_ff == BK_EMIT);
   end

   assign rsp_ch.scl_out = scl_ff;
   assign rsp_ch.sda_out = sda_ff;
   assign rsp_ch.status  = status_ff;
   assign rsp_ch.rx_byte = rx_ff;
   assign rsp_ch.last    = last_ff;

   // Command, phase counters and the phase word.
   always_comb begin
      cmd_in       = cmd_ff;
      k_in         = k_ff;
      sub_in       = sub_ff;
      tx_in        = tx_ff;
      scl_level_in = scl_level_ff;
      cnt_in       = cnt_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      status_in    = status_ff;
      rx_in        = rx_ff;
      last_in      = last_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               cmd_in = pop_data;
               k_in   = '0;
               sub_in = 2'd0;
               tx_in  = pop_data.tx;
            end
         end
         BK_LOAD: begin
            scl_in       = lv.scl;
            sda_in       = lv.sda;
            scl_level_in = lv.scl;
            last_in      = is_last;
            status_in    = is_last ? cmd_ff.status : ST_READY;
            rx_in        = is_last ? cmd_ff.rx : 8'd0;
         end
         BK_EMIT: begin
            if (rsp_ch.ready) cnt_in = TICKS_W'(1);
         end
         BK_HOLD: begin
            cnt_in = cnt_ff + 1'b1;
            // Step to the next phase; a send byte bit spans three phases.
            if (hold_done && !last_ff) begin
               k_in = k_ff + 1'b1;
               if (sub_ff == 2'd2) begin
                  sub_in = 2'd0;
                  tx_in  = {tx_ff[6:0], 1'b0};
               end else begin
                  sub_in = sub_ff + 1'b1;
               end
            end
         end
         default: cnt_in = cnt_ff;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         scl_level_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scl_level_ff <= scl_level_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      k_ff      <= k_in;
      sub_ff    <= sub_in;
      tx_ff     <= tx_in;
      cnt_ff    <= cnt_in;
      scl_ff    <= scl_in;
      sda_ff    <= sda_in;
      status_ff <= status_in;
      rx_ff     <= rx_in;
      last_ff   <= last_in;
   end

endmodule

/* rtl/i2c_bit_level_master.sv */
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// Bit level I2C bus master: turns bus commands into timed SCL/SDA phases.
//
//   Channel   Direction  Word
//   req_ch    in         opcode, tx_byte, sda_samples (one bus command)
//   rsp_ch    out        scl_out, sda_out, status, rx_byte, last (one phase)
//   csr_ch    in         data: phase length in clock cycles
//
// Each phase is built in BK_LOAD, offered on rsp_ch in BK_EMIT until taken, then
// held in BK_HOLD for the phase length; BK_IDLE then takes the next command.
// A two-word queue takes commands while others run.
// Reset clears the queue, sets the held SCL level low and the phase length to 200.
// A stall on rsp_ch freezes the sequencer; req_ch stalls only when full.
// ----------------------------------------------------------------------------
module i2c_bit_level_master import i2cb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   i2cb_req_if.sink   req_ch,
   i2cb_rsp_if.source rsp_ch,
   i2cb_csr_if.sink   csr_ch
);

   logic [TICKS_W-1:0] phase_ticks_ff, phase_ticks_in;
   logic               push_valid, push_ready;
   cmd_type            push_data;
   logic               pop_valid, pop_ready;
   cmd_type            pop_data;

   // Phase length register; writes are always taken.
   assign csr_ch.ready   = 1'b1;
   assign phase_ticks_in = csr_ch.valid ? csr_ch.data : phase_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RESET;
      end else begin
         phase_ticks_ff <= phase_ticks_in;
      end
   end

   // Front part: accept and classify commands.
   i2cb_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Command queue.
   i2cb_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back part: phase sequencer.
   i2cb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .phase_ticks (phase_ticks_ff),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_ch      (rsp_ch)
   );

`ifndef SYNTHESIS
   // Status and received byte appear only on the final phase.
   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.last |-> rsp_ch.status == ST_READY && rsp_ch.rx_byte == 8'd0)
      else $error("status or rx_byte set on a phase that is not the last");

   // Every taken phase is followed by a hold, never by another phase at once.
   a_hold_after_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready |=> !rsp_ch.valid)
      else $error("phase word followed without a hold");

   // A busy bus ends the command with both lines high.
   a_busy_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status == ST_BUSY |-> rsp_ch.scl_out && rsp_ch.sda_out
         && rsp_ch.last)
      else $error("bus busy reported with wrong line levels");

   // The sequencer never takes a word from the queue while a phase is offered.
   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !pop_ready)
      else $error("sequencer takes a command while a phase is pending");
`endif

endmodule

/* bench/i2c_bit_level_master_tb.sv */
// ----------------------------------------------------------------------------
// i2c_bit_level_master_tb
// Self-checking bench for the I2C bit level master. Bus commands are fed
// through the request channel, each accepted command is expanded into the
// SCL/SDA phase words it must produce, and every phase word taken from the
// response channel is compared field by field with the oldest expected one.
// The run covers a directed set of commands, random bus transfers and noise,
// several phase lengths from 1 to 65535, random idling on both channels and
// one long response stall that backs up the command queue.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_tb import i2cb_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   // The opcode left free by the command set; the block drops it.
   localparam logic [2:0] OP_UNUSED = 3'd7;

   // Slowest correct run: about 110 commands of up to 27 phases at short
   // phase lengths with stalls, the directed words at the reset phase length,
   // six phases at the longest phase length plus the final settle, and the one
   // long response stall. CYCLE_LIMIT ends a run that hangs.
   localparam int CYCLE_LIMIT       = 4_000_000;
   localparam int LONG_STALL_CYCLES = 2000;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] tx_byte;
      logic [8:0] sda_samples;
   } bus_command_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic [2:0] status;
      logic [7:0] rx;
      logic       last;
   } bus_phase_type;

   logic clock = 1'b0;
   logic reset;

   i2cb_req_if req_ch ();
   i2cb_rsp_if rsp_ch ();
   i2cb_csr_if csr_ch ();

   i2c_bit_level_master uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Bench state.
   bus_command_type command_backlog[$];
   bus_phase_type   expected_phases[$];
   bus_command_type offered_cmd;
   logic            scl_held;
   int              cur_ticks          = 200;
   int              sender_idle_pct    = 0;
   int              receiver_stall_pct = 0;
   logic            pressure_armed     = 1'b0;
   logic            long_stall         = 1'b0;
   int              commands_accepted  = 0;
   int              phases_checked     = 0;
   int              input_stall_cycles = 0;
   int              mismatches         = 0;
   int              cycle_count        = 0;

   always #4 clock = ~clock;

   // ------------------------------------------------------------------------
   // Phase prediction
   // ------------------------------------------------------------------------

   // Queue a phase that is not the final one of its command.
   function automatic void add_phase(input logic scl, input logic sda);
      expected_phases.push_back('{scl: scl, sda: sda, status: ST_READY, rx: 8'h00,
                                  last: 1'b0});
      scl_held = scl;
   endfunction

   // Queue the final phase of a command with its status and received byte.
   function automatic void add_last(input logic scl, input logic sda,
                                    input logic [2:0] status, input logic [7:0] rx);
      expected_phases.push_back('{scl: scl, sda: sda, status: status, rx: rx,
                                  last: 1'b1});
      scl_held = scl;
   endfunction

   // Expand one accepted command into the phase words it must produce.
   task automatic expand_command(input bus_command_type c);
      logic [7:0] rx;
      logic       b;
      rx = 8'h00;
      case (c.opcode)
         OP_START: begin
            add_phase(scl_held, 1'b1);
            if (!c.sda_samples[0]) begin
               // Data line held low by someone else: the bus is busy.
               add_last(1'b1, 1'b1, ST_BUSY, 8'h00);
            end else begin
               add_phase(1'b1, 1'b1);
               add_phase(1'b1, 1'b0);
               add_last(1'b0, 1'b0, c.sda_samples[1] ? ST_ERROR : ST_READY, 8'h00);
            end
         end
         OP_SENSOR_START: begin
            add_phase(1'b0, 1'b1);
            if (!c.sda_samples[0]) begin
               add_last(1'b1, 1'b1, ST_BUSY, 8'h00);
            end else begin
               add_phase(1'b1, 1'b1);
               add_phase(1'b1, 1'b0);
               add_phase(1'b0, 1'b0);
               add_phase(1'b1, 1'b0);
               add_phase(1'b1, 1'b1);
               add_last(1'b0, 1'b1, ST_READY, 8'h00);
            end
         end
         OP_STOP: begin
            add_phase(scl_held, 1'b0);
            add_phase(1'b1, 1'b0);
            add_last(1'b1, 1'b1, ST_READY, 8'h00);
         end
         OP_ACK: begin
            add_phase(scl_held, 1'b0);
            add_phase(1'b1, 1'b0);
            add_phase(1'b0, 1'b0);
            add_last(1'b0, 1'b1, ST_READY, 8'h00);
         end
         OP_NACK: begin
            add_phase(scl_held, 1'b1);
            add_phase(1'b1, 1'b1);
            add_last(1'b0, 1'b1, ST_READY, 8'h00);
         end
         OP_SEND: begin
            // Each data bit is a low-high-low clock pulse, MSB first.
            for (int i = 7; i >= 0; i--) begin
               b = c.tx_byte[i];
               add_phase(1'b0, b);
               add_phase(1'b1, b);
               add_phase(1'b0, b);
            end
            // Acknowledge slot: the slave pulls the data line low to ack.
            add_phase(1'b0, 1'b1);
            add_phase(1'b1, 1'b1);
            add_last(1'b0, 1'b1, c.sda_samples[0] ? ST_NACK : ST_ACK, 8'h00);
         end
         OP_RECV: begin
            add_phase(1'b0, 1'b1);
            for (int i = 0; i < 8; i++) begin
               add_phase(1'b1, 1'b1);
               rx = {rx[6:0], c.sda_samples[i]};
               if (i < 7) add_phase(1'b0, 1'b1);
               else add_last(1'b0, 1'b1, ST_READY, rx);
            end
         end
         default: begin
            // The unused opcode produces nothing and leaves the lines alone.
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   // Print one line for every mismatch and count it.
   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   task automatic compare_field(input string name, input int got, input int exp);
      if (got != exp)
         report_mismatch($sformatf("phase word %0d: %s is %0d, expected %0d",
                                   phases_checked, name, got, exp));
   endtask

   // ------------------------------------------------------------------------
   // Command driver: offers backlog words with random idle gaps.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expand_command(offered_cmd);
            commands_accepted++;
         end else if (req_ch.valid) begin
            input_stall_cycles++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (command_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               offered_cmd = command_backlog.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.opcode      <= offered_cmd.opcode;
               req_ch.tx_byte     <= offered_cmd.tx_byte;
               req_ch.sda_samples <= offered_cmd.sda_samples;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Phase monitor: random stalls, long hold-off, and the field checks.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_phases.size() == 0) begin
               report_mismatch($sformatf("unexpected phase word scl %0d sda %0d status %0d",
                                         rsp_ch.scl_out, rsp_ch.sda_out, rsp_ch.status));
            end else begin
               bus_phase_type exp;
               exp = expected_phases.pop_front();
               compare_field("scl_out", rsp_ch.scl_out, exp.scl);
               compare_field("sda_out", rsp_ch.sda_out, exp.sda);
               compare_field("status",  rsp_ch.status,  exp.status);
               compare_field("rx_byte", rsp_ch.rx_byte, exp.rx);
               compare_field("last",    rsp_ch.last,    exp.last);
            end
            phases_checked++;
         end
         rsp_ch.ready <= !long_stall && ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Long response hold-off so the command queue fills and stalls the input.
   initial begin : back_pressure
      wait (pressure_armed);
      @(posedge clock);
      long_stall <= 1'b1;
      repeat (LONG_STALL_CYCLES) @(posedge clock);
      long_stall <= 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d phase words still expected",
                  cycle_count, expected_phases.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus sequencing
   // ------------------------------------------------------------------------

   task automatic push_cmd(input logic [2:0] op, input logic [7:0] tx, input logic [8:0] smp);
      command_backlog.push_back('{opcode: op, tx_byte: tx, sda_samples: smp});
   endtask

   // Mostly complete bus transfers with random content, the rest single
   // random commands (the unused opcode among them, not counted).
   task automatic queue_random_commands(input int count);
      int   made;
      logic [2:0] op;
      made = 0;
      while (made < count) begin
         if ($urandom_range(9) < 6) begin
            // Start (mostly clean), address byte, one data byte sent or received with ack/nack, stop.
            push_cmd(OP_START, 8'($urandom_range(255)),
                     ($urandom_range(9) < 8) ? 9'h001 | 9'($urandom_range(511)) & 9'h1FD
                                             : 9'($urandom_range(511)));
            push_cmd(OP_SEND, 8'($urandom_range(255)), 9'($urandom_range(511)));
            if ($urandom_range(1) == 1) begin
               push_cmd(OP_RECV, 8'($urandom_range(255)), 9'($urandom_range(511)));
               push_cmd($urandom_range(1) ? OP_ACK : OP_NACK, 8'($urandom_range(255)),
                        9'($urandom_range(511)));
               made += 1;
            end else begin
               push_cmd(OP_SEND, 8'($urandom_range(255)), 9'($urandom_range(511)));
            end
            push_cmd(OP_STOP, 8'($urandom_range(255)), 9'($urandom_range(511)));
            made += 4;
         end else begin
            op = 3'($urandom_range(7));
            push_cmd(op, 8'($urandom_range(255)), 9'($urandom_range(511)));
            if (op != OP_UNUSED) made++;
         end
      end
   endtask

   // Wait until every queued word is accepted and every phase has arrived,
   // then let a phase length plus margin pass so the block is truly idle.
   task automatic wait_idle();
      @(negedge clock);
      while (command_backlog.size() != 0 || req_ch.valid || expected_phases.size() != 0)
         @(negedge clock);
      repeat (cur_ticks + 40) @(negedge clock);
   endtask

   // Write the phase length register; returns on a falling edge.
   task automatic write_ticks(input int ticks);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= 16'(ticks);
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      cur_ticks = ticks;
      @(negedge clock);
   endtask

   task automatic set_pace(input int send_pct, input int recv_pct);
      sender_idle_pct    = send_pct;
      receiver_stall_pct = recv_pct;
   endtask

   initial begin
      reset              = 1'b1;
      scl_held           = 1'b0;
      req_ch.valid       = 1'b0;
      req_ch.opcode      = OP_START;
      req_ch.tx_byte     = 8'h00;
      req_ch.sda_samples = 9'h000;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.data        = 16'h0000;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A short transfer at the reset phase length.
      push_cmd(OP_START, 8'h00, 9'h001);
      push_cmd(OP_SEND,  8'hA5, 9'h000);
      push_cmd(OP_RECV,  8'h00, 9'h0AA);
      push_cmd(OP_STOP,  8'h00, 9'h000);
      wait_idle();

      // Directed corners at the shortest phase length: busy and error
      // starts, held clock high and low before ack/nack/stop, sensor start
      // both ways, byte extremes, ack and nack, ignored sample bits, and
      // the unused opcode.
      write_ticks(1);
      push_cmd(OP_START,        8'h00, 9'h1FE);
      push_cmd(OP_START,        8'h00, 9'h003);
      push_cmd(OP_STOP,         8'h00, 9'h000);
      push_cmd(OP_ACK,          8'h00, 9'h000);
      push_cmd(OP_NACK,         8'h00, 9'h000);
      push_cmd(OP_STOP,         8'hFF, 9'h1FF);
      push_cmd(OP_NACK,         8'h00, 9'h000);
      push_cmd(OP_SENSOR_START, 8'h00, 9'h000);
      push_cmd(OP_SENSOR_START, 8'hFF, 9'h1FF);
      push_cmd(OP_ACK,          8'hFF, 9'h1FF);
      push_cmd(OP_SEND,         8'h00, 9'h000);
      push_cmd(OP_SEND,         8'hFF, 9'h1FF);
      push_cmd(OP_SEND,         8'h80, 9'h1FE);
      push_cmd(OP_SEND,         8'h01, 9'h001);
      push_cmd(OP_RECV,         8'h00, 9'h000);
      push_cmd(OP_RECV,         8'hFF, 9'h1FF);
      push_cmd(OP_RECV,         8'h00, 9'h155);
      push_cmd(OP_UNUSED,       8'hFF, 9'h1FF);
      push_cmd(OP_START,        8'h00, 9'h001);
      push_cmd(OP_STOP,         8'h00, 9'h000);
      wait_idle();

      // Random traffic under each idling pattern.
      write_ticks(3);
      set_pace(0, 0);
      queue_random_commands(16);
      wait_idle();

      write_ticks(2);
      set_pace(57, 0);
      queue_random_commands(16);
      wait_idle();

      write_ticks(7);
      set_pace(0, 57);
      queue_random_commands(16);
      wait_idle();

      write_ticks($urandom_range(20, 1));
      set_pace(6, 6);
      queue_random_commands(16);
      wait_idle();

      // Response held off for a long stretch while commands keep coming.
      write_ticks(2);
      set_pace(0, 0);
      pressure_armed = 1'b1;
      queue_random_commands(8);
      wait_idle();

      // Longest phase length with a couple of short commands.
      write_ticks(65535);
      set_pace(6, 6);
      push_cmd(OP_STOP, 8'h00, 9'h000);
      push_cmd(OP_NACK, 8'h00, 9'h000);
      wait_idle();

      $display("Checked %0d phase words from %0d accepted commands;",
               phases_checked, commands_accepted);
      $display("phase lengths 200, 1..20 and 65535; input held off for %0d cycles.",
               input_stall_cycles);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches found", mismatches);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/i2cb_pkg.sv
rtl/i2cb_if.sv
rtl/i2cb_front.sv
rtl/i2cb_cmd_queue.sv
rtl/i2cb_back.sv
rtl/i2c_bit_level_master.sv
bench/i2c_bit_level_master_tb.sv
